/* hdl/slpc_pkg.sv */
package slpc_pkg;

  // Input item kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_MODE    = 3'd1;
  localparam logic [2:0] KIND_BATTERY = 3'd2;
  localparam logic [2:0] KIND_TX      = 3'd3;
  localparam logic [2:0] KIND_RX      = 3'd4;

  // Display modes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_USB    = 3'd1;
  localparam logic [2:0] MODE_TCP    = 3'd2;
  localparam logic [2:0] MODE_LOWBAT = 3'd3;
  localparam logic [2:0] MODE_UPDATE = 3'd4;
  localparam logic [2:0] MODE_ERROR  = 3'd5;

  // Register indexes (byte address bits [4:2])
  localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] REG_BATT_SHOW  = 3'd1;
  localparam logic [2:0] REG_LINK_PULSE = 3'd2;
  localparam logic [2:0] REG_SLOW_FLASH = 3'd3;
  localparam logic [2:0] REG_UPD_FLASH  = 3'd4;
  localparam logic [2:0] REG_FAST_FLASH = 3'd5;
  localparam logic [2:0] REG_BREATHE    = 3'd6;

  localparam logic [6:0]  BRIGHT_RESET  = 7'd100;
  localparam logic [15:0] SHOW_RESET    = 16'd5000;
  localparam logic [15:0] PULSE_RESET   = 16'd50;
  localparam logic [15:0] SLOW_RESET    = 16'd1000;
  localparam logic [15:0] UPD_RESET     = 16'd250;
  localparam logic [15:0] FAST_RESET    = 16'd150;
  localparam logic [15:0] BREATHE_RESET = 16'd3000;

  localparam logic [6:0]  BRIGHT_MAX  = 7'd100;
  localparam logic [7:0]  DUTY_OFF    = 8'd255;
  localparam logic [7:0]  FULL_LEVEL  = 8'd255;
  localparam logic [7:0]  BATT_HIGH   = 8'd70;
  localparam logic [7:0]  BATT_LOW    = 8'd31;
  localparam logic [15:0] BREATHE_MIN = 16'd2;

  // Shared divider: 32 remainder steps for the phase, 8 quotient steps otherwise
  localparam logic [4:0]  MOD_LAST   = 5'd31;
  localparam logic [4:0]  DIV_LAST   = 5'd7;
  localparam logic [22:0] HUNDRED_X128 = 23'd12800;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] mode;
    logic [7:0] battery_pct;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rgb_red_duty;
    logic [7:0] rgb_green_duty;
    logic [7:0] rgb_blue_duty;
    logic [7:0] link_red_duty;
    logic [7:0] link_green_duty;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_LOAD_LVL,
    ST_LVL,
    ST_LOAD_SCL,
    ST_SCL,
    ST_LOAD_FULL,
    ST_FULL
  } seq_state_e;

endpackage

/* hdl/status_led_pattern_controller_top.sv */
// Status LED pattern controller.
// Input channel in_valid_i/in_stall_o/in_item_i carries one request: a 1 ms
// tick, a mode change, a battery show, or a transmit/receive pulse. Every
// accepted request yields exactly one result on out_valid_o/out_stall_i/
// out_item_o: the five inverted LED duties held after that request.
// Each request walks one shared bit-serial divider: 32 remainder steps
// for the breathing phase (elapsed time modulo the period), then three
// 8-step quotient passes (breathing level, level times brightness over
// 100, full intensity times brightness over 100), each after a load
// state; the commit takes the last step of the final pass. No new
// request is taken until that commit is done.
// The result sits in an output register; the divider runs on while the
// receiver stalls, and only the commit waits for the output to drain.
// Reset turns every LED off (duty 255), selects idle mode, clears all timers
// and loads the register defaults. Registers sit at APB byte address 4*index;
// the user must write them only with no request in progress; not enforced.
module status_led_pattern_controller_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  slpc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output slpc_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import slpc_pkg::*;

  seq_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] n_q, n_d;
  logic [24:0] r_q, r_d;
  logic [22:0] d_q, d_d;
  logic [7:0]  q_q, q_d;
  logic [7:0]  lvl_duty_q, lvl_duty_d;
  in_item_t    item_q, item_d;

  logic [6:0]  bright_q;
  logic [15:0] show_q, lp_q, slow_q, upd_q, fast_q, bp_q;

  logic [2:0]  cur_mode_q, cur_mode_d;
  logic [31:0] anim_q, anim_d, bat_q, bat_d, pul_q, pul_d;
  logic        lit_q, lit_d, bat_act_q, bat_act_d;
  logic        pul_act_q, pul_act_d, pul_red_q, pul_red_d;
  out_item_t   held_q, held_d;
  logic        out_valid_q, out_valid_d;

  logic        commit_go;
  logic        cfg_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHT_RESET;
      show_q   <= SHOW_RESET;
      lp_q     <= PULSE_RESET;
      slow_q   <= SLOW_RESET;
      upd_q    <= UPD_RESET;
      fast_q   <= FAST_RESET;
      bp_q     <= BREATHE_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_BRIGHTNESS: begin
          bright_q <= (pwdata[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : pwdata[6:0];
        end
        REG_BATT_SHOW:  show_q <= pwdata[15:0];
        REG_LINK_PULSE: lp_q   <= pwdata[15:0];
        REG_SLOW_FLASH: slow_q <= pwdata[15:0];
        REG_UPD_FLASH:  upd_q  <= pwdata[15:0];
        REG_FAST_FLASH: fast_q <= pwdata[15:0];
        REG_BREATHE:    bp_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_BRIGHTNESS: prdata = {25'd0, bright_q};
      REG_BATT_SHOW:  prdata = {16'd0, show_q};
      REG_LINK_PULSE: prdata = {16'd0, lp_q};
      REG_SLOW_FLASH: prdata = {16'd0, slow_q};
      REG_UPD_FLASH:  prdata = {16'd0, upd_q};
      REG_FAST_FLASH: prdata = {16'd0, fast_q};
      REG_BREATHE:    prdata = {16'd0, bp_q};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_MOD;
      ST_MOD:       if (cnt_q == '0) state_d = ST_LOAD_LVL;
      ST_LOAD_LVL:  state_d = ST_LVL;
      ST_LVL:       if (cnt_q == '0) state_d = ST_LOAD_SCL;
      ST_LOAD_SCL:  state_d = ST_SCL;
      ST_SCL:       if (cnt_q == '0) state_d = ST_LOAD_FULL;
      ST_LOAD_FULL: state_d = ST_FULL;
      ST_FULL:      if (cnt_q == '0 && (!out_valid_q || !out_stall_i)) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    commit_go  = (state_q == ST_FULL) && (cnt_q == '0) && (!out_valid_q || !out_stall_i);
  end

  // ---------------- bit-serial divider datapath ----------------
  logic [16:0] mod_shift, mod_next;
  logic        mod_ge;
  logic        div_ge;
  logic [24:0] div_rem;
  logic [15:0] phase;
  logic        first_half;
  logic [16:0] tri_x;
  logic [24:0] tri_x_w;
  logic [7:0]  level;
  logic [14:0] lvl_prod, full_prod;

  assign mod_shift  = {r_q[15:0], n_q[31]};
  assign mod_ge     = mod_shift >= {1'b0, bp_q};
  assign mod_next   = mod_ge ? (mod_shift - {1'b0, bp_q}) : mod_shift;
  assign div_ge     = r_q >= {2'b00, d_q};
  assign div_rem    = r_q - {2'b00, d_q};
  assign phase      = r_q[15:0];
  assign first_half = {phase, 1'b0} < {1'b0, bp_q};
  assign tri_x      = first_half ? {1'b0, phase} : ({1'b0, bp_q} - {1'b0, phase});
  assign tri_x_w    = {8'd0, tri_x};
  assign level      = (bp_q < BREATHE_MIN) ? 8'd0 : q_q;
  assign lvl_prod   = {7'd0, level} * {8'd0, bright_q};
  assign full_prod  = {7'd0, FULL_LEVEL} * {8'd0, bright_q};

  always_comb begin
    cnt_d      = cnt_q;
    n_d        = n_q;
    r_d        = r_q;
    d_d        = d_q;
    q_d        = q_q;
    lvl_duty_d = lvl_duty_q;
    item_d     = item_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_item_i;
          n_d    = anim_q + 32'd1;
          r_d    = '0;
          cnt_d  = MOD_LAST;
        end
      end
      ST_MOD: begin
        r_d   = {8'd0, mod_next};
        n_d   = {n_q[30:0], 1'b0};
        cnt_d = cnt_q - 5'd1;
      end
      ST_LOAD_LVL: begin
        // 510*x as (x<<9) - (x<<1)
        r_d   = (tri_x_w << 9) - (tri_x_w << 1);
        d_d   = {bp_q, 7'd0};
        cnt_d = DIV_LAST;
      end
      ST_LOAD_SCL: begin
        r_d   = {10'd0, lvl_prod};
        d_d   = HUNDRED_X128;
        cnt_d = DIV_LAST;
      end
      ST_LOAD_FULL: begin
        lvl_duty_d = DUTY_OFF - q_q;
        r_d        = {10'd0, full_prod};
        d_d        = HUNDRED_X128;
        cnt_d      = DIV_LAST;
      end
      ST_LVL, ST_SCL, ST_FULL: begin
        if (cnt_q != '0 || state_q != ST_FULL || commit_go) begin
          // hold the last quotient while the commit waits
          if (!(state_q == ST_FULL && cnt_q == '0)) begin
            r_d   = div_ge ? div_rem : r_q;
            q_d   = {q_q[6:0], div_ge};
            d_d   = {1'b0, d_q[22:1]};
            cnt_d = cnt_q - 5'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------- commit of the item's effect ----------------
  logic [31:0] anim_inc, bat_inc, pul_inc;
  logic [15:0] flash_half;
  logic        flash_due, lit_new;
  logic [7:0]  full_duty, lit_duty;

  assign anim_inc = anim_q + 32'd1;
  assign bat_inc  = bat_q + 32'd1;
  assign pul_inc  = pul_q + 32'd1;

  always_comb begin
    case (cur_mode_q)
      MODE_LOWBAT: flash_half = slow_q;
      MODE_UPDATE: flash_half = upd_q;
      default:     flash_half = fast_q;
    endcase
  end

  assign flash_due = anim_inc >= {16'd0, flash_half};
  assign lit_new   = flash_due ? !lit_q : lit_q;
  assign lit_duty  = lit_new ? full_duty : DUTY_OFF;

  // In ST_FULL at cnt 0 the quotient of 255*brightness/100 still needs its
  // final step; finish it here for the commit.
  assign full_duty = DUTY_OFF - {q_q[6:0], div_ge};

  always_comb begin
    cur_mode_d = cur_mode_q;
    anim_d     = anim_q;
    bat_d      = bat_q;
    pul_d      = pul_q;
    lit_d      = lit_q;
    bat_act_d  = bat_act_q;
    pul_act_d  = pul_act_q;
    pul_red_d  = pul_red_q;
    held_d     = held_q;
    case (item_q.kind)
      KIND_TICK: begin
        anim_d = anim_inc;
        bat_d  = bat_inc;
        pul_d  = pul_inc;
        if (bat_act_q) begin
          if (bat_inc >= {16'd0, show_q}) begin
            bat_act_d = 1'b0;
            anim_d    = '0;
          end
        end else begin
          case (cur_mode_q)
            MODE_USB: begin
              held_d.rgb_red_duty   = DUTY_OFF;
              held_d.rgb_green_duty = DUTY_OFF;
              held_d.rgb_blue_duty  = full_duty;
            end
            MODE_TCP: begin
              held_d.rgb_red_duty   = DUTY_OFF;
              held_d.rgb_green_duty = full_duty;
              held_d.rgb_blue_duty  = DUTY_OFF;
            end
            MODE_LOWBAT, MODE_UPDATE, MODE_ERROR: begin
              if (flash_due) anim_d = '0;
              lit_d                 = lit_new;
              held_d.rgb_red_duty   = lit_duty;
              held_d.rgb_green_duty = (cur_mode_q == MODE_UPDATE) ? lit_duty : DUTY_OFF;
              held_d.rgb_blue_duty  = DUTY_OFF;
            end
            default: begin
              held_d.rgb_red_duty   = DUTY_OFF;
              held_d.rgb_green_duty = DUTY_OFF;
              held_d.rgb_blue_duty  = lvl_duty_q;
            end
          endcase
        end
        if (pul_act_q) begin
          held_d.link_red_duty   = pul_red_q ? full_duty : DUTY_OFF;
          held_d.link_green_duty = pul_red_q ? DUTY_OFF : full_duty;
          if (pul_inc >= {16'd0, lp_q}) pul_act_d = 1'b0;
        end else begin
          held_d.link_red_duty   = DUTY_OFF;
          held_d.link_green_duty = DUTY_OFF;
        end
      end
      KIND_MODE: begin
        if (item_q.mode != cur_mode_q) begin
          cur_mode_d = item_q.mode;
          anim_d     = '0;
          lit_d      = 1'b0;
        end
      end
      KIND_BATTERY: begin
        bat_act_d             = 1'b1;
        bat_d                 = '0;
        held_d.rgb_red_duty   = DUTY_OFF;
        held_d.rgb_green_duty = DUTY_OFF;
        held_d.rgb_blue_duty  = DUTY_OFF;
        if (item_q.battery_pct > BATT_HIGH) begin
          held_d.rgb_blue_duty = full_duty;
        end else if (item_q.battery_pct >= BATT_LOW) begin
          held_d.rgb_green_duty = full_duty;
        end else begin
          held_d.rgb_red_duty = full_duty;
        end
      end
      KIND_TX, KIND_RX: begin
        pul_act_d = 1'b1;
        pul_red_d = (item_q.kind == KIND_TX);
        pul_d     = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (commit_go) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = held_q;

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      cur_mode_q  <= MODE_IDLE;
      anim_q      <= '0;
      bat_q       <= '0;
      pul_q       <= '0;
      lit_q       <= 1'b0;
      bat_act_q   <= 1'b0;
      pul_act_q   <= 1'b0;
      pul_red_q   <= 1'b0;
      held_q      <= {5{DUTY_OFF}};
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (commit_go) begin
        cur_mode_q <= cur_mode_d;
        anim_q     <= anim_d;
        bat_q      <= bat_d;
        pul_q      <= pul_d;
        lit_q      <= lit_d;
        bat_act_q  <= bat_act_d;
        pul_act_q  <= pul_act_d;
        pul_red_q  <= pul_red_d;
        held_q     <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    r_q        <= r_d;
    d_q        <= d_d;
    q_q        <= q_d;
    lvl_duty_q <= lvl_duty_d;
    item_q     <= item_d;
  end

  // ---------------- assertions ----------------
  a_valid_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(commit_go))
    else $error("result raised without a commit");

  a_bright_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bright_q <= BRIGHT_MAX)
    else $error("brightness above 100");

  a_phase_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD_LVL && bp_q != 16'd0) |-> (r_q[16:0] < {1'b0, bp_q}))
    else $error("breathing phase not reduced below the period");

  a_mod_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD && cnt_q == '0) |=> (state_q == ST_LOAD_LVL))
    else $error("remainder pass ended at the wrong step");

  a_commit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FULL && cnt_q == '0 && out_valid_q && out_stall_i)
      |=> (state_q == ST_FULL && $stable(held_q)))
    else $error("commit overwrote a result still waiting");

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slpc_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 80;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned PHASE_COUNT     = 8;
  localparam int unsigned ITEMS_PER_PHASE = 103;
  localparam int unsigned PRINT_CAP       = 200;
  localparam logic [2:0]  CODE_MAX        = 3'd7;
  localparam logic [2:0]  REG_UNMAPPED    = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  status_led_pattern_controller_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies
  logic [6:0]  bright_pct     = BRIGHT_RESET;
  logic [15:0] show_ms        = SHOW_RESET;
  logic [15:0] pulse_len_ms   = PULSE_RESET;
  logic [15:0] slow_half_ms   = SLOW_RESET;
  logic [15:0] update_half_ms = UPD_RESET;
  logic [15:0] fast_half_ms   = FAST_RESET;
  logic [15:0] breathe_ms     = BREATHE_RESET;

  // LED state copies
  logic [2:0]  shown_mode = MODE_IDLE;
  logic [31:0] anim_ms    = '0;
  logic        flash_on   = 1'b0;
  logic        batt_on    = 1'b0;
  logic [31:0] batt_ms    = '0;
  logic        pulse_on   = 1'b0;
  logic        pulse_red  = 1'b0;
  logic [31:0] pulse_ms   = '0;
  out_item_t   lit_duties = '1;

  in_item_t    req_backlog[$];
  out_item_t   duties_due[$];
  out_item_t   due_duties;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned hold_pct = 0;

  function automatic logic [7:0] scale_duty(input int unsigned intensity);
    int unsigned dim;
    dim = (intensity * bright_pct) / BRIGHT_MAX;
    return DUTY_OFF - dim[7:0];
  endfunction

  function automatic void show_rgb(input int unsigned r, input int unsigned g,
                                   input int unsigned b);
    lit_duties.rgb_red_duty   = scale_duty(r);
    lit_duties.rgb_green_duty = scale_duty(g);
    lit_duties.rgb_blue_duty  = scale_duty(b);
  endfunction

  // Advance the LED state by one request and return the duties it leaves.
  function automatic out_item_t led_duties_after(input in_item_t req);
    int unsigned half;
    int unsigned period;
    int unsigned phase;
    int unsigned level;
    int unsigned lit;
    case (req.kind)
      KIND_TICK: begin
        anim_ms  = anim_ms + 1;
        batt_ms  = batt_ms + 1;
        pulse_ms = pulse_ms + 1;
        if (batt_on) begin
          // RGB keeps the battery colour on the tick that ends the override
          if (batt_ms >= show_ms) begin
            batt_on = 1'b0;
            anim_ms = '0;
          end
        end else begin
          case (shown_mode)
            MODE_USB: show_rgb(0, 0, FULL_LEVEL);
            MODE_TCP: show_rgb(0, FULL_LEVEL, 0);
            MODE_LOWBAT, MODE_UPDATE, MODE_ERROR: begin
              half = (shown_mode == MODE_LOWBAT) ? slow_half_ms :
                     (shown_mode == MODE_UPDATE) ? update_half_ms : fast_half_ms;
              if (anim_ms >= half) begin
                anim_ms  = '0;
                flash_on = !flash_on;
              end
              lit = flash_on ? FULL_LEVEL : 0;
              show_rgb(lit, (shown_mode == MODE_UPDATE) ? lit : 0, 0);
            end
            default: begin
              period = breathe_ms;
              level = 0;
              if (period >= BREATHE_MIN) begin
                phase = anim_ms % period;
                if (2 * phase < period)
                  level = (2 * FULL_LEVEL * phase) / period;
                else
                  level = (2 * FULL_LEVEL * (period - phase)) / period;
              end
              show_rgb(0, 0, level);
            end
          endcase
        end
        if (pulse_on) begin
          lit_duties.link_red_duty   = pulse_red ? scale_duty(FULL_LEVEL) : DUTY_OFF;
          lit_duties.link_green_duty = pulse_red ? DUTY_OFF : scale_duty(FULL_LEVEL);
          if (pulse_ms >= pulse_len_ms)
            pulse_on = 1'b0;
        end else begin
          lit_duties.link_red_duty   = DUTY_OFF;
          lit_duties.link_green_duty = DUTY_OFF;
        end
      end
      KIND_MODE: begin
        if (req.mode != shown_mode) begin
          shown_mode = req.mode;
          anim_ms    = '0;
          flash_on   = 1'b0;
        end
      end
      KIND_BATTERY: begin
        batt_on = 1'b1;
        batt_ms = '0;
        if (req.battery_pct > BATT_HIGH)
          show_rgb(0, 0, FULL_LEVEL);
        else if (req.battery_pct >= BATT_LOW)
          show_rgb(0, FULL_LEVEL, 0);
        else
          show_rgb(FULL_LEVEL, 0, 0);
      end
      KIND_TX, KIND_RX: begin
        pulse_on  = 1'b1;
        pulse_red = (req.kind == KIND_TX);
        pulse_ms  = '0;
      end
      default: ;
    endcase
    return lit_duties;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP)
      $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Request driver: hold a stalled request, else load the next or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o)
        duties_due.push_back(led_duties_after(in_item_i));
      if (!in_valid_i || !in_stall_o) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= req_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      out_stall_i <= 1'b0;
    else
      out_stall_i <= ($urandom_range(99) < hold_pct);
  end

  // Duty monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (duties_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", out_item_o));
      end else begin
        due_duties = duties_due.pop_front();
        for (int f = 0; f < 5; f++)
          if (out_item_o[8*f +: 8] !== due_duties[8*f +: 8])
            flag_mismatch($sformatf("duty slot %0d got %0d want %0d (item %h, want %h)",
                                    f, out_item_o[8*f +: 8], due_duties[8*f +: 8],
                                    out_item_o, due_duties));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status_led_pattern_controller_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BRIGHTNESS: bright_pct = (val[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : val[6:0];
      REG_BATT_SHOW:  show_ms        = val[15:0];
      REG_LINK_PULSE: pulse_len_ms   = val[15:0];
      REG_SLOW_FLASH: slow_half_ms   = val[15:0];
      REG_UPD_FLASH:  update_half_ms = val[15:0];
      REG_FAST_FLASH: fast_half_ms   = val[15:0];
      REG_BREATHE:    breathe_ms     = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [6:0] bright, input logic [15:0] show,
                               input logic [15:0] pulse, input logic [15:0] slow,
                               input logic [15:0] upd, input logic [15:0] fast,
                               input logic [15:0] breathe);
    write_reg(REG_BRIGHTNESS, {25'd0, bright});
    write_reg(REG_BATT_SHOW,  {16'd0, show});
    write_reg(REG_LINK_PULSE, {16'd0, pulse});
    write_reg(REG_SLOW_FLASH, {16'd0, slow});
    write_reg(REG_UPD_FLASH,  {16'd0, upd});
    write_reg(REG_FAST_FLASH, {16'd0, fast});
    write_reg(REG_BREATHE,    {16'd0, breathe});
  endtask

  task automatic queue_request(input logic [2:0] kind, input logic [2:0] mode,
                               input logic [7:0] pct);
    in_item_t req;
    req.kind = kind;
    req.mode = mode;
    req.battery_pct = pct;
    req_backlog.push_back(req);
  endtask

  // Drain every request and result, then let the divider run out.
  task automatic wait_for_quiet();
    do @(posedge clk_i);
    while (req_backlog.size() != 0 || in_valid_i || duties_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly ticks, with mode changes, battery shows, pulses and stray kinds.
  function automatic in_item_t random_request();
    logic [13:0]  bits;
    in_item_t     req;
    int unsigned  roll;
    bits = 14'($urandom);
    req  = bits;
    roll = $urandom_range(99);
    if (roll < 60) begin
      req.kind = KIND_TICK;
    end else if (roll < 72) begin
      req.kind = KIND_MODE;
      if ($urandom_range(9) == 0)
        req.mode = 3'($urandom_range(CODE_MAX, MODE_ERROR + 1));
      else
        req.mode = 3'($urandom_range(MODE_ERROR, MODE_IDLE));
    end else if (roll < 80) begin
      req.kind = KIND_BATTERY;
      case ($urandom_range(5))
        0: req.battery_pct = BATT_LOW - 8'd1;
        1: req.battery_pct = BATT_LOW;
        2: req.battery_pct = BATT_HIGH;
        3: req.battery_pct = BATT_HIGH + 8'd1;
        default: ;
      endcase
    end else if (roll < 91) begin
      req.kind = 3'($urandom_range(KIND_RX, KIND_TX));
    end else if (roll < 95) begin
      req.kind = 3'($urandom_range(CODE_MAX, KIND_RX + 1));
    end
    return req;
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short timers so overrides expire within the directed part
    load_settings(7'd127, 16'd3, 16'd2, 16'd1, 16'd2, 16'd0, 16'd1);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);

    queue_request(KIND_TICK, MODE_IDLE, 8'd0);
    queue_request(KIND_BATTERY, MODE_IDLE, 8'd255);
    queue_request(KIND_BATTERY, MODE_IDLE, BATT_HIGH + 8'd1);
    queue_request(KIND_BATTERY, MODE_IDLE, BATT_HIGH);
    queue_request(KIND_BATTERY, MODE_IDLE, BATT_LOW);
    queue_request(KIND_BATTERY, MODE_IDLE, BATT_LOW - 8'd1);
    repeat (3) queue_request(KIND_TICK, MODE_IDLE, 8'd0);
    queue_request(KIND_TX, MODE_IDLE, 8'd0);
    repeat (2) queue_request(KIND_TICK, MODE_IDLE, 8'd0);
    queue_request(KIND_RX, MODE_IDLE, 8'd0);
    queue_request(KIND_TICK, MODE_IDLE, 8'd0);
    queue_request(KIND_MODE, MODE_USB, 8'd0);
    queue_request(KIND_TICK, MODE_IDLE, 8'd0);
    queue_request(KIND_MODE, MODE_TCP, 8'd0);
    queue_request(KIND_TICK, MODE_IDLE, 8'd0);
    queue_request(KIND_MODE, MODE_LOWBAT, 8'd0);
    queue_request(KIND_TICK, MODE_IDLE, 8'd0);
    queue_request(KIND_MODE, MODE_UPDATE, 8'd0);
    queue_request(KIND_TICK, MODE_IDLE, 8'd0);
    queue_request(KIND_MODE, MODE_ERROR, 8'd0);
    queue_request(KIND_TICK, MODE_IDLE, 8'd0);
    queue_request(KIND_MODE, CODE_MAX, 8'd0);
    queue_request(KIND_TICK, MODE_IDLE, 8'd0);
    queue_request(CODE_MAX, MODE_IDLE, 8'd0);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_for_quiet();
      case (ph)
        0: load_settings(BRIGHT_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF);
        1: load_settings(7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        2: load_settings(7'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, BREATHE_MIN);
        3: load_settings(BRIGHT_RESET, SHOW_RESET, PULSE_RESET, SLOW_RESET, UPD_RESET,
                         FAST_RESET, BREATHE_RESET);
        default: load_settings(7'($urandom_range(127)), 16'($urandom_range(30, 1)),
                               16'($urandom_range(12, 1)), 16'($urandom_range(16, 1)),
                               16'($urandom_range(16, 1)), 16'($urandom_range(16, 1)),
                               16'($urandom_range(50, BREATHE_MIN)));
      endcase
      case (ph % 4)
        0: begin send_gap_pct = 0;  hold_pct = 0;  end
        1: begin send_gap_pct = 88; hold_pct = 0;  end
        2: begin send_gap_pct = 0;  hold_pct = 88; end
        default: begin send_gap_pct = 20; hold_pct = 20; end
      endcase
      repeat (ITEMS_PER_PHASE) req_backlog.push_back(random_request());
    end

    wait_for_quiet();
    if (mismatch_count == 0 && duties_due.size() == 0)
      $display("status_led_pattern_controller_top verification clean");
    else
      $display("status_led_pattern_controller_top verification failed");
    $finish;
  end

endmodule
